// ----- rtl/elfsc_pkg.sv -----
// ----------------------------------------------------------------------------
// elfsc_pkg
// Types and constants shared by the ELF32 segment checker modules.
// ----------------------------------------------------------------------------
package elfsc_pkg;

	localparam int unsigned WORD_W    = 32;
	localparam int unsigned S_TDATA_W = 7 * WORD_W;
	localparam int unsigned M_TDATA_W = 72;
	localparam int unsigned M_USED_W  = 4 + 2 * WORD_W;

	localparam logic [WORD_W-1:0] SEG_LOADABLE = 32'd1;
	localparam int unsigned PERM_EXEC_BIT  = 0;
	localparam int unsigned PERM_WRITE_BIT = 1;

	typedef enum logic [0:0] {
		REG_IMAGE_SIZE    = 1'b0,
		REG_ENTRY_ADDRESS = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SEG_OK        = 2'd0,
		SEG_MALFORMED = 2'd1,
		SEG_WX        = 2'd2
	} seg_status_t;

	typedef enum logic [1:0] {
		IMG_OK        = 2'd0,
		IMG_MALFORMED = 2'd1,
		IMG_SECURITY  = 2'd2,
		IMG_NO_LOAD   = 2'd3
	} img_status_t;

	typedef struct packed {
		logic [WORD_W-1:0] seg_kind;
		logic [WORD_W-1:0] file_offset;
		logic [WORD_W-1:0] virt_addr;
		logic [WORD_W-1:0] phys_addr;
		logic [WORD_W-1:0] file_bytes;
		logic [WORD_W-1:0] mem_bytes;
		logic [WORD_W-1:0] perm_flags;
		logic [WORD_W-1:0] align_req;
		logic              last_header;
	} hdr_t;

	typedef struct packed {
		seg_status_t       status;
		logic              loadable;
		logic              entry_hit;
		logic [WORD_W-1:0] start_addr;
		logic [WORD_W-1:0] end_addr;
	} seg_check_t;

	typedef struct packed {
		seg_status_t       seg_status;
		logic              is_loadable;
		logic              image_done;
		img_status_t       image_status;
		logic [WORD_W-1:0] load_base;
		logic [WORD_W-1:0] load_span;
	} result_t;

endpackage

// ----- rtl/elfsc_check.sv -----
// ----------------------------------------------------------------------------
// elfsc_check
// Per-header checks of one loadable segment against image size and entry.
// ----------------------------------------------------------------------------
module elfsc_check
	import elfsc_pkg::*;
(
	input  hdr_t              hdr,
	input  logic [WORD_W-1:0] image_size,
	input  logic [WORD_W-1:0] entry_address,
	output seg_check_t        chk
);

	logic [WORD_W:0]   file_lim;
	logic [WORD_W:0]   mem_end;
	logic [WORD_W-1:0] align_m1;
	logic              range_bad;
	logic              wx;
	logic              align_bad;
	logic              is_exec;

	assign file_lim = {1'b0, hdr.file_offset} + {1'b0, hdr.file_bytes};
	assign mem_end  = {1'b0, hdr.virt_addr} + {1'b0, hdr.mem_bytes};
	assign align_m1 = hdr.align_req - 32'd1;

	assign range_bad = (hdr.mem_bytes < hdr.file_bytes)
		|| file_lim[WORD_W] || (file_lim[WORD_W-1:0] > image_size)
		|| mem_end[WORD_W]
		|| (hdr.virt_addr[1:0] != 2'b00) || (hdr.phys_addr[1:0] != 2'b00);

	assign is_exec   = hdr.perm_flags[PERM_EXEC_BIT];
	assign wx        = hdr.perm_flags[PERM_WRITE_BIT] && is_exec;
	assign align_bad = (hdr.align_req > 32'd1) && ((hdr.align_req & align_m1) != '0);

	always_comb begin
		chk.loadable   = (hdr.seg_kind == SEG_LOADABLE);
		chk.start_addr = hdr.virt_addr;
		chk.end_addr   = mem_end[WORD_W-1:0];
		chk.entry_hit  = is_exec && (entry_address >= hdr.virt_addr)
			&& (entry_address < mem_end[WORD_W-1:0]);
		priority if (!chk.loadable) begin
			chk.status = SEG_OK;
		end else if (range_bad) begin
			chk.status = SEG_MALFORMED;
		end else if (wx) begin
			chk.status = SEG_WX;
		end else if (align_bad) begin
			chk.status = SEG_MALFORMED;
		end else begin
			chk.status = SEG_OK;
		end
	end

endmodule

// ----- rtl/elfsc_track.sv -----
// ----------------------------------------------------------------------------
// elfsc_track
// Image-wide state: address range, load/entry flags, sticky first error.
// Builds the result item and clears the state on the last header.
// ----------------------------------------------------------------------------
module elfsc_track
	import elfsc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic       last_header,
	input  seg_check_t chk,
	output result_t    res
);

	logic [WORD_W-1:0] lowest_start_q;
	logic [WORD_W-1:0] highest_end_q;
	logic              load_found_q;
	logic              entry_found_q;
	seg_status_t       first_error_q;

	logic [WORD_W-1:0] lowest_start_d;
	logic [WORD_W-1:0] highest_end_d;
	logic              load_found_d;
	logic              entry_found_d;
	seg_status_t       first_error_d;
	logic              seg_good;

	assign seg_good = chk.loadable && (chk.status == SEG_OK);

	always_comb begin
		lowest_start_d = lowest_start_q;
		highest_end_d  = highest_end_q;
		load_found_d   = load_found_q;
		entry_found_d  = entry_found_q;
		first_error_d  = first_error_q;
		if (chk.loadable && (chk.status != SEG_OK) && (first_error_q == SEG_OK)) begin
			first_error_d = chk.status;
		end
		if (seg_good) begin
			load_found_d = 1'b1;
			if (chk.start_addr < lowest_start_q) begin
				lowest_start_d = chk.start_addr;
			end
			if (chk.end_addr > highest_end_q) begin
				highest_end_d = chk.end_addr;
			end
			if (chk.entry_hit) begin
				entry_found_d = 1'b1;
			end
		end
	end

	always_comb begin
		res.seg_status   = chk.status;
		res.is_loadable  = chk.loadable;
		res.image_done   = last_header;
		res.image_status = IMG_OK;
		res.load_base    = '0;
		res.load_span    = '0;
		if (last_header) begin
			unique case (first_error_d)
				SEG_MALFORMED: res.image_status = IMG_MALFORMED;
				SEG_WX:        res.image_status = IMG_SECURITY;
				SEG_OK: begin
					if (!load_found_d || !entry_found_d) begin
						res.image_status = IMG_NO_LOAD;
					end else begin
						res.load_base = lowest_start_d;
						res.load_span = highest_end_d - lowest_start_d;
					end
				end
				default: res.image_status = IMG_MALFORMED;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lowest_start_q <= '1;
			highest_end_q  <= '0;
			load_found_q   <= 1'b0;
			entry_found_q  <= 1'b0;
			first_error_q  <= SEG_OK;
		end else if (adv) begin
			if (last_header) begin
				lowest_start_q <= '1;
				highest_end_q  <= '0;
				load_found_q   <= 1'b0;
				entry_found_q  <= 1'b0;
				first_error_q  <= SEG_OK;
			end else begin
				lowest_start_q <= lowest_start_d;
				highest_end_q  <= highest_end_d;
				load_found_q   <= load_found_d;
				entry_found_q  <= entry_found_d;
				first_error_q  <= first_error_d;
			end
		end
	end

endmodule

// ----- rtl/elf32_segment_checker_unit.sv -----
// ----------------------------------------------------------------------------
// elf32_segment_checker_unit
// Checks a stream of ELF32 program headers and reports the image verdict.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one program header per transaction; s_tlast marks the last
//   header of an image, s_tuser the segment type word.
//   m_* returns one result per header; m_tlast flags the image verdict,
//   m_tuser says whether the header was loadable.
//   cfg_* writes image_size (index 0) and entry_address (index 1); it is
//   always ready. The user must write it only while no header is in flight;
//   the block itself does not enforce this.
// Pipeline: input register, then checks and image state, then result register.
// Throughput: one header per cycle while m_tready is high; the image state
//   (range, flags, first error) is updated together with the result register.
// Reset: clears both pipeline stages, the image state and the registers.
// Stall: a held result keeps its register; one further header waits in the
//   input register and s_tready falls only when both stages are full.
// ----------------------------------------------------------------------------
module elf32_segment_checker_unit
	import elfsc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// file_offset, virt_addr, phys_addr, file_bytes, mem_bytes, perm_flags, align_req
	input  logic [S_TDATA_W-1:0] s_tdata,
	// seg_kind
	input  logic [WORD_W-1:0]    s_tuser,
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// seg_status[1:0], image_status[3:2], load_base[35:4], load_span[67:36], zero pad
	output logic [M_TDATA_W-1:0] m_tdata,
	// is_loadable
	output logic                 m_tuser,
	output logic                 m_tlast,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  cfg_reg_t             cfg_index,
	input  logic [WORD_W-1:0]    cfg_data
);

	logic [WORD_W-1:0] image_size_q;
	logic [WORD_W-1:0] entry_address_q;

	logic       vld_s1;
	hdr_t       hdr_s1;
	logic       vld_s2;
	result_t    res_s2;
	hdr_t       hdr_in;
	seg_check_t chk;
	result_t    res;
	logic       adv;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q    <= '0;
			entry_address_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_IMAGE_SIZE:    image_size_q    <= cfg_data;
				REG_ENTRY_ADDRESS: entry_address_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		hdr_in.seg_kind    = s_tuser;
		hdr_in.file_offset = s_tdata[0*WORD_W +: WORD_W];
		hdr_in.virt_addr   = s_tdata[1*WORD_W +: WORD_W];
		hdr_in.phys_addr   = s_tdata[2*WORD_W +: WORD_W];
		hdr_in.file_bytes  = s_tdata[3*WORD_W +: WORD_W];
		hdr_in.mem_bytes   = s_tdata[4*WORD_W +: WORD_W];
		hdr_in.perm_flags  = s_tdata[5*WORD_W +: WORD_W];
		hdr_in.align_req   = s_tdata[6*WORD_W +: WORD_W];
		hdr_in.last_header = s_tlast;
	end

	assign adv      = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				vld_s1 <= s_tvalid;
			end
			if (adv) begin
				vld_s2 <= 1'b1;
			end else if (m_tready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			hdr_s1 <= hdr_in;
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	elfsc_check u_check (
		.hdr           (hdr_s1),
		.image_size    (image_size_q),
		.entry_address (entry_address_q),
		.chk           (chk)
	);

	elfsc_track u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.last_header (hdr_s1.last_header),
		.chk         (chk),
		.res         (res)
	);

	assign m_tvalid = vld_s2;
	assign m_tuser  = res_s2.is_loadable;
	assign m_tlast  = res_s2.image_done;
	assign m_tdata  = {{(M_TDATA_W - M_USED_W){1'b0}}, res_s2.load_span, res_s2.load_base,
		res_s2.image_status, res_s2.seg_status};

endmodule

// ----- rtl/elfsc_checker.sv -----
// ----------------------------------------------------------------------------
// elfsc_checker
// Port-level checks on the result stream of the segment checker.
// ----------------------------------------------------------------------------
module elfsc_checker
	import elfsc_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic                 m_tuser,
	input logic                 m_tlast
);

	// held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
			&& $stable(m_tuser) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_nonload_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[1:0] == SEG_OK)
		else $error("non-loadable header reported a segment error");

	a_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[M_USED_W-1:2] == '0)
		else $error("image fields set on a header that is not last");

	a_bad_image: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3:2] != IMG_OK |-> m_tdata[M_USED_W-1:4] == '0)
		else $error("base or size reported for a rejected image");

	a_codes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'b11 && m_tdata[M_TDATA_W-1:M_USED_W] == '0)
		else $error("bad segment code or non-zero padding");

endmodule

bind elf32_segment_checker_unit elfsc_checker u_elfsc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
